[rtl/svbcf_pkg.sv]
// Shared types and constants of the servo bus command framer.
// No dependencies; every other file of the block but svbcf_if imports it.
package svbcf_pkg;

   localparam logic [7:0] HDR_BYTE = 8'h55;
   localparam logic signed [7:0] OFS_LIMIT = 8'sd125;

   // Depth of the command queue between the front and back parts.
   localparam int QDEPTH = 2;
   localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW = $clog2(QDEPTH + 1);

   typedef enum logic [3:0] {
      CMD_SET_ID     = 4'd0,
      CMD_GET_ID     = 4'd1,
      CMD_SET_POS    = 4'd2,
      CMD_GET_POS    = 4'd3,
      CMD_SET_OFFSET = 4'd4,
      CMD_GET_OFFSET = 4'd5,
      CMD_SET_LIMIT  = 4'd6,
      CMD_GET_LIMIT  = 4'd7,
      CMD_SET_LOAD   = 4'd8
   } cmd_type;

   typedef enum logic [7:0] {
      OP_MOVE        = 8'd1,
      OP_ID_WRITE    = 8'd13,
      OP_ID_READ     = 8'd14,
      OP_OFS_ADJUST  = 8'd17,
      OP_OFS_WRITE   = 8'd18,
      OP_OFS_READ    = 8'd19,
      OP_LIMIT_WRITE = 8'd20,
      OP_LIMIT_READ  = 8'd21,
      OP_POS_READ    = 8'd28,
      OP_LOAD_WRITE  = 8'd31
   } opcode_type;

   // Register indexes of the configuration port.
   typedef enum logic {
      REG_ANGLE_MAX     = 1'b0,
      REG_MOVE_TIME_MAX = 1'b1
   } reg_index_type;

   // One classified command as it waits for the serializer.
   typedef struct packed {
      logic [7:0]      id;
      opcode_type      op;
      logic [3:0][7:0] prm;
      logic [2:0]      np;
      logic [7:0]      chk0;   // checksum of the first frame
      logic            two;    // a second, parameterless write frame follows
      logic [7:0]      chk1;   // checksum of the second frame
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[rtl/svbcf_if.sv]
// Handshake channels of the servo bus command framer: command in, bytes out.
// Depends on nothing; the payload widths follow the block's fields.
interface svbcf_req_if;
   logic              valid;
   logic              ready;
   logic [3:0]        command;
   logic [7:0]        servo_id;
   logic [15:0]       value_a;
   logic [15:0]       value_b;
   logic signed [7:0] offset_value;

   modport source (output valid, command, servo_id, value_a, value_b, offset_value,
                   input ready);
   modport sink (input valid, command, servo_id, value_a, value_b, offset_value,
                 output ready);
endinterface

interface svbcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;
   logic       last;

   modport source (output valid, tx_byte, frame_end, last, input ready);
   modport sink (input valid, tx_byte, frame_end, last, output ready);
endinterface

[rtl/svbcf_front.sv]
// Front part: accepts a command, saturates its values and builds the frame
// descriptor with checksums. Depends on svbcf_pkg.
module svbcf_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            command,
   input  logic [7:0]            servo_id,
   input  logic [15:0]           value_a,
   input  logic [15:0]           value_b,
   input  logic signed [7:0]     offset_value,
   input  logic [15:0]           angle_max,
   input  logic [15:0]           move_time_max,
   input  svbcf_pkg::qstat_type  qstat,
   output logic                  push,
   output svbcf_pkg::desc_type   desc
);
   import svbcf_pkg::*;

   logic              known;
   logic [15:0]       lim_b;
   logic [15:0]       sat_a;
   logic [15:0]       sat_b;
   logic signed [7:0] ofs;
   logic [7:0]        sum;

   always_comb begin
      lim_b = (command == CMD_SET_POS) ? move_time_max : angle_max;
      sat_a = (value_a > angle_max) ? angle_max : value_a;
      sat_b = (value_b > lim_b) ? lim_b : value_b;
      if (offset_value < -OFS_LIMIT) begin
         ofs = -OFS_LIMIT;
      end else if (offset_value > OFS_LIMIT) begin
         ofs = OFS_LIMIT;
      end else begin
         ofs = offset_value;
      end
   end

   always_comb begin
      desc      = '0;
      desc.id   = servo_id;
      desc.op   = OP_ID_READ;
      known     = 1'b1;
      case (command)
         CMD_SET_ID: begin
            desc.op     = OP_ID_WRITE;
            desc.prm[0] = value_a[7:0];
            desc.np     = 3'd1;
         end
         CMD_GET_ID:     desc.op = OP_ID_READ;
         CMD_SET_POS, CMD_SET_LIMIT: begin
            desc.op  = (command == CMD_SET_POS) ? OP_MOVE : OP_LIMIT_WRITE;
            desc.prm = {sat_b[15:8], sat_b[7:0], sat_a[15:8], sat_a[7:0]};
            desc.np  = 3'd4;
         end
         CMD_GET_POS:    desc.op = OP_POS_READ;
         CMD_SET_OFFSET: begin
            desc.op     = OP_OFS_ADJUST;
            desc.prm[0] = ofs;
            desc.np     = 3'd1;
            desc.two    = 1'b1;
         end
         CMD_GET_OFFSET: desc.op = OP_OFS_READ;
         CMD_GET_LIMIT:  desc.op = OP_LIMIT_READ;
         CMD_SET_LOAD: begin
            desc.op     = OP_LOAD_WRITE;
            desc.prm[0] = {7'd0, (value_a[7:0] != 8'd0)};
            desc.np     = 3'd1;
         end
         default:        known = 1'b0;
      endcase
      // Unused parameter bytes are zero, so they drop out of the sum.
      sum = desc.id + {5'd0, desc.np} + 8'd3 + desc.op
          + desc.prm[0] + desc.prm[1] + desc.prm[2] + desc.prm[3];
      desc.chk0 = ~sum;
      desc.chk1 = ~(desc.id + 8'd3 + OP_OFS_WRITE);
   end

   assign req_ready = !qstat.full;
   assign push      = req_valid && req_ready && known;

endmodule

[rtl/svbcf_queue.sv]
// Two-entry queue of frame descriptors between the front and back parts.
// Depends on svbcf_pkg.
module svbcf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  svbcf_pkg::desc_type   wr_desc,
   input  logic                  pop,
   output svbcf_pkg::desc_type   rd_desc,
   output svbcf_pkg::qstat_type  qstat
);
   import svbcf_pkg::*;

   desc_type           mem [QDEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]     count_ff, count_in;

   function automatic logic [QAW-1:0] ptr_next(input logic [QAW-1:0] p);
      return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_desc;
      end
   end

   assign rd_desc     = mem[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCW'(QDEPTH));
   assign qstat.empty = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop) else $error("queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a write");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCW'(QDEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with the count");

endmodule

[rtl/svbcf_back.sv]
// Back part: serializes one queued descriptor into frame bytes, one byte
// per cycle unless stalled, into the output register. Needs svbcf_pkg.
module svbcf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  svbcf_pkg::desc_type   desc,
   input  svbcf_pkg::qstat_type  qstat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            tx_byte,
   output logic                  frame_end,
   output logic                  last
);
   import svbcf_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       frame_ff, frame_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;

   logic       advance;
   logic [2:0] cur_np;
   logic [7:0] cur_op;
   logic [7:0] cur_chk;
   logic [3:0] prm_idx;
   logic       is_chk;

   assign advance = !qstat.empty && (!valid_ff || rsp_ready);

   always_comb begin
      cur_np  = frame_ff ? 3'd0 : desc.np;
      cur_op  = frame_ff ? OP_OFS_WRITE : desc.op;
      cur_chk = frame_ff ? desc.chk1 : desc.chk0;
      prm_idx = idx_ff - 4'd5;
      is_chk  = (idx_ff == 4'd5 + {1'b0, cur_np});

      case (idx_ff)
         4'd0, 4'd1: byte_in = HDR_BYTE;
         4'd2:       byte_in = desc.id;
         4'd3:       byte_in = {5'd0, cur_np} + 8'd3;
         4'd4:       byte_in = cur_op;
         default:    byte_in = is_chk ? cur_chk : desc.prm[prm_idx[1:0]];
      endcase
      end_in  = is_chk;
      last_in = is_chk && (!desc.two || frame_ff);
      pop     = advance && last_in;

      idx_in   = idx_ff;
      frame_in = frame_ff;
      if (advance) begin
         if (is_chk) begin
            idx_in   = '0;
            frame_in = !last_in;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      valid_in = advance ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         frame_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         frame_ff <= frame_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign tx_byte   = byte_ff;
   assign frame_end = end_ff;
   assign last      = last_ff;

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> end_ff) else $error("last byte is not a checksum");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> valid_ff && $stable(byte_ff))
      else $error("output byte changed under stall");

   a_idx_reset_after_frame: assert property (@(posedge clock) disable iff (reset)
      (advance && is_chk) |=> idx_ff == '0)
      else $error("byte index not rewound after a checksum");

endmodule

[rtl/servo_bus_command_framer_core.sv]
// Top level of the servo bus command framer: configuration registers and
// the front part, queue and back part. Depends on svbcf_pkg and svbcf_if.
//
// Each accepted command produces its bus frames at one byte per clock
// cycle unless the output stalls: 6 to 10 bytes for a single frame and
// 13 for a set-offset, which sends an adjust frame, then a write frame.
// Commands are accepted one per cycle while
// the two-entry descriptor queue has room, so a new command can be taken
// while earlier bytes are still going out. Unknown command codes are
// accepted and dropped without output. Configuration registers sit at byte
// addresses 0 (angle_max) and 4 (move_time_max) and read back their value.
module servo_bus_command_framer_core (
   input  logic        clock,
   input  logic        reset,
   svbcf_req_if.sink   req_ch,
   svbcf_rsp_if.source rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import svbcf_pkg::*;

   logic [15:0] angle_max_ff, angle_max_in;
   logic [15:0] time_max_ff, time_max_in;
   logic        csr_wr;

   qstat_type   qstat;
   desc_type    wr_desc;
   desc_type    rd_desc;
   logic        push;
   logic        pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      angle_max_in = angle_max_ff;
      time_max_in  = time_max_ff;
      if (csr_wr) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_ANGLE_MAX:     angle_max_in = csr_pwdata[15:0];
            REG_MOVE_TIME_MAX: time_max_in  = csr_pwdata[15:0];
            default:           angle_max_in = angle_max_ff;
         endcase
      end
      csr_prdata = (reg_index_type'(csr_paddr[2]) == REG_MOVE_TIME_MAX)
                 ? {16'd0, time_max_ff} : {16'd0, angle_max_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_max_ff <= 16'd1000;
         time_max_ff  <= 16'd30000;
      end else begin
         angle_max_ff <= angle_max_in;
         time_max_ff  <= time_max_in;
      end
   end

   svbcf_front u_front (
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .command       (req_ch.command),
      .servo_id      (req_ch.servo_id),
      .value_a       (req_ch.value_a),
      .value_b       (req_ch.value_b),
      .offset_value  (req_ch.offset_value),
      .angle_max     (angle_max_ff),
      .move_time_max (time_max_ff),
      .qstat         (qstat),
      .push          (push),
      .desc          (wr_desc)
   );

   svbcf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_desc (wr_desc),
      .pop     (pop),
      .rd_desc (rd_desc),
      .qstat   (qstat)
   );

   svbcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .desc      (rd_desc),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .tx_byte   (rsp_ch.tx_byte),
      .frame_end (rsp_ch.frame_end),
      .last      (rsp_ch.last)
   );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for servo_bus_command_framer_core: servo commands are sent,
// and the bus bytes that come out are checked against a frame predictor held here.
// Depends on svbcf_pkg, the svbcf_req_if and svbcf_rsp_if interfaces and the block's RTL.
module testbench;
   import svbcf_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [3:0]        command;
      logic [7:0]        servo_id;
      logic [15:0]       value_a;
      logic [15:0]       value_b;
      logic signed [7:0] offset_value;
   } servo_command_type;

   typedef struct {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       last;
   } bus_byte_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   svbcf_req_if req_ch ();
   svbcf_rsp_if rsp_ch ();

   servo_command_type command_queue [$];
   bus_byte_type      expected_bytes [$];
   servo_command_type next_command;
   servo_command_type seen_command;
   bus_byte_type      wanted;

   // Limits as the predictor sees them; they follow every register write.
   logic [15:0] angle_limit;
   logic [15:0] time_limit;

   int send_gap_pct;
   int recv_gap_pct;
   int long_hold_requests;
   int long_holds_done;
   int hold_left;
   int quiet_cycles;
   int errors;
   int commands_accepted;
   int commands_ignored;
   int bytes_checked;
   int limit_settings;

   servo_bus_command_framer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] saturate16(input logic [15:0] value, input logic [15:0] lim);
      return (value > lim) ? lim : value;
   endfunction

   // Appends one frame: header, id, length, opcode, parameters, inverted sum.
   task automatic push_frame(input logic [7:0] id, input opcode_type op,
                             input logic [31:0] params, input int nparams,
                             input bit ends_command);
      logic [7:0]   frame [$];
      logic [7:0]   sum;
      bus_byte_type entry;
      frame.push_back(HDR_BYTE);
      frame.push_back(HDR_BYTE);
      frame.push_back(id);
      frame.push_back(8'(nparams + 3));
      frame.push_back(op);
      for (int i = 0; i < nparams; i++) frame.push_back(params[8*i +: 8]);
      sum = 8'h00;
      for (int i = 2; i < frame.size(); i++) sum = sum + frame[i];
      frame.push_back(~sum);
      foreach (frame[i]) begin
         entry.tx_byte = frame[i];
         entry.frame_end = (i == frame.size() - 1);
         entry.last = entry.frame_end && ends_command;
         expected_bytes.push_back(entry);
      end
   endtask

   task automatic predict_frames(input servo_command_type c);
      logic [15:0]       lo;
      logic [15:0]       hi;
      logic signed [7:0] ofs;
      case (c.command)
         CMD_SET_ID: push_frame(c.servo_id, OP_ID_WRITE, {24'h0, c.value_a[7:0]}, 1, 1'b1);
         CMD_GET_ID: push_frame(c.servo_id, OP_ID_READ, 32'h0, 0, 1'b1);
         CMD_SET_POS: begin
            lo = saturate16(c.value_a, angle_limit);
            hi = saturate16(c.value_b, time_limit);
            push_frame(c.servo_id, OP_MOVE, {hi, lo}, 4, 1'b1);
         end
         CMD_GET_POS: push_frame(c.servo_id, OP_POS_READ, 32'h0, 0, 1'b1);
         CMD_SET_OFFSET: begin
            ofs = c.offset_value;
            if (ofs > OFS_LIMIT) ofs = OFS_LIMIT;
            if (ofs < -OFS_LIMIT) ofs = -OFS_LIMIT;
            push_frame(c.servo_id, OP_OFS_ADJUST, {24'h0, ofs}, 1, 1'b0);
            push_frame(c.servo_id, OP_OFS_WRITE, 32'h0, 0, 1'b1);
         end
         CMD_GET_OFFSET: push_frame(c.servo_id, OP_OFS_READ, 32'h0, 0, 1'b1);
         CMD_SET_LIMIT: begin
            lo = saturate16(c.value_a, angle_limit);
            hi = saturate16(c.value_b, angle_limit);
            push_frame(c.servo_id, OP_LIMIT_WRITE, {hi, lo}, 4, 1'b1);
         end
         CMD_GET_LIMIT: push_frame(c.servo_id, OP_LIMIT_READ, 32'h0, 0, 1'b1);
         CMD_SET_LOAD:
            push_frame(c.servo_id, OP_LOAD_WRITE, {31'h0, c.value_a[7:0] != 8'h00}, 1, 1'b1);
         default: ;
      endcase
   endtask

   task automatic queue_command(input logic [3:0] command, input logic [7:0] id,
                                input logic [15:0] va, input logic [15:0] vb,
                                input logic signed [7:0] ofs);
      servo_command_type c;
      c.command = command;
      c.servo_id = id;
      c.value_a = va;
      c.value_b = vb;
      c.offset_value = ofs;
      command_queue.push_back(c);
   endtask

   // Values cluster around the active limit so that saturation is hit often.
   function automatic logic [15:0] pick_value(input logic [15:0] lim);
      case ($urandom_range(3))
         0: return lim + 16'($urandom_range(4)) - 16'd2;
         1: return 16'($urandom_range(15));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   task automatic queue_random(input int count);
      int          queued;
      logic [3:0]  command;
      logic [15:0] lim;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(19) < 18) command = 4'($urandom_range(CMD_SET_LOAD));
         else command = 4'($urandom_range(15, 9));
         lim = (command == CMD_SET_POS && $urandom_range(1)) ? time_limit : angle_limit;
         queue_command(command, 8'($urandom_range(255)), pick_value(angle_limit),
                       pick_value(lim), 8'($urandom_range(255)));
         if (command <= CMD_SET_LOAD) queued++;
      end
   endtask

   task automatic csr_write(input reg_index_type index, input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_limits(input logic [15:0] angle, input logic [15:0] move_time);
      csr_write(REG_ANGLE_MAX, angle);
      csr_write(REG_MOVE_TIME_MAX, move_time);
      angle_limit = angle;
      time_limit = move_time;
      limit_settings++;
   endtask

   // Holds the sender back until every expected byte is out, then lets the
   // block finish any dropped command before the next register write.
   task automatic drain();
      do @(posedge clock);
      while (command_queue.size() != 0 || req_ch.valid || expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (command_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            next_command = command_queue.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.command <= next_command.command;
            req_ch.servo_id <= next_command.servo_id;
            req_ch.value_a <= next_command.value_a;
            req_ch.value_b <= next_command.value_b;
            req_ch.offset_value <= next_command.offset_value;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_holds_done != long_hold_requests) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= LONG_HOLD_CYCLES;
         long_holds_done <= long_hold_requests;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_command.command = req_ch.command;
            seen_command.servo_id = req_ch.servo_id;
            seen_command.value_a = req_ch.value_a;
            seen_command.value_b = req_ch.value_b;
            seen_command.offset_value = req_ch.offset_value;
            predict_frames(seen_command);
            if (req_ch.command <= CMD_SET_LOAD) commands_accepted++;
            else commands_ignored++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: byte %h (frame_end %b, last %b) arrived with none expected",
                        $time, rsp_ch.tx_byte, rsp_ch.frame_end, rsp_ch.last);
               errors++;
            end else begin
               wanted = expected_bytes.pop_front();
               if ({rsp_ch.tx_byte, rsp_ch.frame_end, rsp_ch.last} !==
                   {wanted.tx_byte, wanted.frame_end, wanted.last}) begin
                  $display("%0t: expected byte %h frame_end %b last %b, got %h %b %b",
                           $time, wanted.tx_byte, wanted.frame_end, wanted.last,
                           rsp_ch.tx_byte, rsp_ch.frame_end, rsp_ch.last);
                  errors++;
               end
               bytes_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel)
      begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d bytes still expected",
                  $time, WATCHDOG_LIMIT, expected_bytes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.command = '0;
      req_ch.servo_id = '0;
      req_ch.value_a = '0;
      req_ch.value_b = '0;
      req_ch.offset_value = '0;
      rsp_ch.ready = 1'b0;
      angle_limit = 16'd1000;
      time_limit = 16'd30000;
      long_hold_requests = 0;
      long_holds_done = 0;
      quiet_cycles = 0;
      errors = 0;
      commands_accepted = 0;
      commands_ignored = 0;
      bytes_checked = 0;
      limit_settings = 1;
      send_gap_pct = 22;
      recv_gap_pct = 55;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed commands under the reset limits.
      queue_command(CMD_SET_ID, 8'h00, 16'h0000, 16'h0000, 8'sd0);
      queue_command(CMD_SET_ID, 8'hFF, 16'hFFFF, 16'hFFFF, -8'sd1);
      queue_command(CMD_SET_ID, 8'h12, 16'hAB00, 16'h0000, 8'sd0);
      queue_command(CMD_GET_ID, 8'hA5, 16'h0000, 16'h0000, 8'sd0);
      queue_command(CMD_SET_POS, 8'h01, 16'd0, 16'd0, 8'sd0);
      queue_command(CMD_SET_POS, 8'h02, 16'd1000, 16'd30000, 8'sd0);
      queue_command(CMD_SET_POS, 8'h03, 16'd1001, 16'd30001, 8'sd0);
      queue_command(CMD_SET_POS, 8'hFE, 16'hFFFF, 16'hFFFF, 8'sd0);
      queue_command(CMD_GET_POS, 8'h5A, 16'h0000, 16'h0000, 8'sd0);
      queue_command(CMD_SET_OFFSET, 8'h04, 16'h0000, 16'h0000, -8'sd128);
      queue_command(CMD_SET_OFFSET, 8'h05, 16'h0000, 16'h0000, 8'sd127);
      queue_command(CMD_SET_OFFSET, 8'h06, 16'h0000, 16'h0000, -8'sd125);
      queue_command(CMD_SET_OFFSET, 8'h07, 16'h0000, 16'h0000, 8'sd125);
      queue_command(CMD_SET_OFFSET, 8'h08, 16'h0000, 16'h0000, 8'sd0);
      queue_command(CMD_SET_OFFSET, 8'h09, 16'h0000, 16'h0000, -8'sd1);
      queue_command(CMD_GET_OFFSET, 8'h0A, 16'h0000, 16'h0000, 8'sd0);
      queue_command(CMD_SET_LIMIT, 8'h0B, 16'h0000, 16'hFFFF, 8'sd0);
      queue_command(CMD_SET_LIMIT, 8'h0C, 16'hFFFF, 16'd1000, 8'sd0);
      queue_command(CMD_GET_LIMIT, 8'h0D, 16'h0000, 16'h0000, 8'sd0);
      queue_command(CMD_SET_LOAD, 8'h0E, 16'h0000, 16'h0000, 8'sd0);
      queue_command(CMD_SET_LOAD, 8'h0F, 16'h0100, 16'h0000, 8'sd0);
      queue_command(CMD_SET_LOAD, 8'h10, 16'h0001, 16'h0000, 8'sd0);
      queue_command(CMD_SET_LOAD, 8'h11, 16'hFFFF, 16'h0000, 8'sd0);
      queue_command(4'd9, 8'h20, 16'hFFFF, 16'hFFFF, -8'sd1);
      queue_command(4'd15, 8'h21, 16'hFFFF, 16'hFFFF, -8'sd1);
      queue_random(60);
      drain();

      // Zero limits force every position, limit and time to zero.
      write_limits(16'd0, 16'd0);
      queue_random(40);
      drain();

      send_gap_pct = 55;
      recv_gap_pct = 22;
      write_limits(16'hFFFF, 16'hFFFF);
      queue_random(50);
      drain();

      write_limits(16'($urandom_range(65534, 1)), 16'($urandom_range(65534, 1)));
      queue_random(50);
      drain();

      // Full rate with one long receiver hold-off so the input backs up.
      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_limits(16'd4095, 16'd1);
      queue_random(60);
      long_hold_requests++;
      drain();

      write_limits(16'd1000, 16'd30000);
      queue_random(50);
      drain();

      $display("Sent %0d framed commands and %0d unknown codes across %0d limit settings;",
               commands_accepted, commands_ignored, limit_settings);
      $display("checked %0d bus bytes with random stalls, a long hold-off and full rate.",
               bytes_checked);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
